// ===== rtl/core/cpm_pkg.sv =====
// ----------------------------------------------------------------------------
// cpm_pkg: shared constants, types and functions
// Fixed-point constants and CORDIC/exponent tables for the complex power map.
// ----------------------------------------------------------------------------
package cpm_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int CNT_W           = 16;
   localparam int CFG_W           = 31;

   localparam logic [CFG_W-1:0] SHIFT_A_RST = 31'd65536;
   localparam logic [CFG_W-1:0] SHIFT_A_MIN = 31'd66;
   localparam int INVALID_CODE = -1000;

   localparam int FRAC_W = 30;
   localparam int STEPS  = 30;

   localparam logic [29:0] POW_Q30   = 30'd715112055;
   localparam logic [28:0] THIRD_Q30 = 29'd357556027;
   localparam logic [29:0] KINV_Q30  = 30'd652032874;
   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   localparam int MANT_W  = 31;
   localparam int LG_W    = 38;
   localparam int U_W     = 37;
   localparam int N_W     = U_W - FRAC_W;
   localparam int R0_POINT = 26;
   localparam int Z_W     = 35;
   localparam int PHI_W   = 34;
   localparam int ROT_W   = 46;
   localparam int RES_W   = ROT_W - 4;

   localparam int LOG_LAT  = 34;
   localparam int ATAN_LAT = 33;
   localparam int EXP_LAT  = 35;
   localparam int ROT_LAT  = 32;

   typedef struct packed {
      logic             bad;
      logic             zero;
      logic [CNT_W-1:0] cnt;
   } side_type;

   function automatic logic [29:0] atan_q30(input int k);
      unique case (k)
         0: return 30'd843314856;
         1: return 30'd497837829;
         2: return 30'd263043836;
         3: return 30'd133525158;
         4: return 30'd67021686;
         5: return 30'd33543515;
         6: return 30'd16775850;
         7: return 30'd8388437;
         8: return 30'd4194282;
         9: return 30'd2097149;
         default: return 30'((longint'(1) << (FRAC_W - k)) - 1);
      endcase
   endfunction

   function automatic longint unsigned isqrt64(input longint unsigned v);
      longint unsigned rem_v;
      longint unsigned res;
      longint unsigned bit_v;
      rem_v = v;
      res   = 0;
      bit_v = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (rem_v >= res + bit_v) begin
            rem_v = rem_v - (res + bit_v);
            res   = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // k-th successive square root of two in Q.30, k from 1
   function automatic logic [30:0] exp_root(input int k);
      longint unsigned c;
      c = isqrt64(64'd1 << 61);
      for (int j = 1; j < k; j++) begin
         c = isqrt64(c << 30);
      end
      return 31'(c);
   endfunction

endpackage

// ===== rtl/core/cpm_delay.sv =====
// ----------------------------------------------------------------------------
// cpm_delay: enabled shift line
// Carries side data and the angle alongside the arithmetic stages.
// ----------------------------------------------------------------------------
module cpm_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] line_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         line_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign q = line_ff[DEPTH-1];

endmodule

// ===== rtl/core/cpm_log2.sv =====
// ----------------------------------------------------------------------------
// cpm_log2: squared magnitude and its base-2 logarithm
// Square, sum, normalize, then one squaring bit step per stage (Q.30 out).
// ----------------------------------------------------------------------------
module cpm_log2 #(
   parameter int COORD_WIDTH = cpm_pkg::COORD_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [COORD_WIDTH:0]       x,
   input  logic signed [COORD_WIDTH:0]       y,
   output logic signed [cpm_pkg::LG_W-1:0]   lg
);

   localparam int SH    = (COORD_WIDTH > 32) ? (COORD_WIDTH - 32) : 0;
   localparam int MAG_W = COORD_WIDTH - SH;
   localparam int SUM_W = 2 * MAG_W;
   localparam int E_W   = $clog2(SUM_W);
   localparam int INT_W = cpm_pkg::LG_W - cpm_pkg::FRAC_W;
   localparam int STEPS = cpm_pkg::STEPS;
   localparam int MW    = cpm_pkg::MANT_W;

   logic [COORD_WIDTH:0] abs_x, abs_y;
   logic [MAG_W-1:0]     ax, ay;
   logic [SUM_W-1:0]     sqx_in, sqy_in;
   logic [SUM_W-1:0]     sqx_ff, sqy_ff;
   logic [SUM_W-1:0]     sum_ff, sum2_ff;
   logic [E_W-1:0]       e_in, e_ff;
   logic [SUM_W-1:0]     norm;

   logic [MW-1:0]                  m_ff [0:STEPS];
   logic [cpm_pkg::FRAC_W-1:0]     f_ff [0:STEPS];
   logic [E_W-1:0]                 ex_ff [0:STEPS];
   logic signed [INT_W-1:0]        lg_int;

   assign abs_x  = x[COORD_WIDTH] ? (COORD_WIDTH+1)'(-x) : x;
   assign abs_y  = y[COORD_WIDTH] ? (COORD_WIDTH+1)'(-y) : y;
   assign ax     = MAG_W'(abs_x >> SH);
   assign ay     = MAG_W'(abs_y >> SH);
   assign sqx_in = ax * ax;
   assign sqy_in = ay * ay;

   always_comb begin
      e_in = '0;
      for (int i = 0; i < SUM_W; i++) begin
         if (sum_ff[i]) e_in = E_W'(i);
      end
   end

   assign norm = sum2_ff << (E_W'(SUM_W - 1) - e_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         sqx_ff   <= sqx_in;
         sqy_ff   <= sqy_in;
         sum_ff   <= sqx_ff + sqy_ff;
         sum2_ff  <= sum_ff;
         e_ff     <= e_in;
         m_ff[0]  <= norm[SUM_W-1 -: MW];
         f_ff[0]  <= '0;
         ex_ff[0] <= e_ff;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_sq
      logic [2*MW-1:0] sq;
      logic [MW:0]     t;
      assign sq = m_ff[i] * m_ff[i];
      assign t  = sq[2*MW-1:cpm_pkg::FRAC_W];
      always_ff @(posedge clock) begin
         if (en) begin
            m_ff[i+1]  <= t[MW] ? t[MW:1] : t[MW-1:0];
            f_ff[i+1]  <= f_ff[i] | (cpm_pkg::FRAC_W'(t[MW]) << (cpm_pkg::FRAC_W - 1 - i));
            ex_ff[i+1] <= ex_ff[i];
         end
      end
   end

   assign lg_int = INT_W'(ex_ff[STEPS]) + INT_W'(2 * SH - 32);
   assign lg     = {lg_int, f_ff[STEPS]};

endmodule

// ===== rtl/core/cpm_atan.sv =====
// ----------------------------------------------------------------------------
// cpm_atan: vectoring CORDIC angle scaled by the exponent
// Half-plane fold, one CORDIC step per stage, then a split multiply.
// ----------------------------------------------------------------------------
module cpm_atan #(
   parameter int COORD_WIDTH = cpm_pkg::COORD_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [COORD_WIDTH:0]       x,
   input  logic signed [COORD_WIDTH:0]       y,
   output logic signed [cpm_pkg::PHI_W-1:0]  phi
);

   localparam int V_W   = COORD_WIDTH + 3;
   localparam int Z_W   = cpm_pkg::Z_W;
   localparam int STEPS = cpm_pkg::STEPS;
   localparam int LO_W  = 17;
   localparam logic signed [Z_W-1:0] PI_Z = Z_W'(cpm_pkg::PI_Q30);

   logic signed [V_W-1:0] vx_ff [0:STEPS];
   logic signed [V_W-1:0] vy_ff [0:STEPS];
   logic signed [Z_W-1:0] z_ff  [0:STEPS];
   logic signed [V_W-1:0] xe, ye;

   logic [Z_W-1:0]           zmag;
   logic [LO_W+29:0]         plo_ff;
   logic [Z_W-LO_W+29:0]     phi_ff;
   logic                     neg_ff;
   logic [Z_W+29:0]          psum;
   logic [Z_W-1:0]           pq;

   assign xe = V_W'(x);
   assign ye = V_W'(y);

   always_ff @(posedge clock) begin
      if (en) begin
         if (x < 0) begin
            vx_ff[0] <= -xe;
            vy_ff[0] <= -ye;
            z_ff[0]  <= (y >= 0) ? PI_Z : -PI_Z;
         end else begin
            vx_ff[0] <= xe;
            vy_ff[0] <= ye;
            z_ff[0]  <= '0;
         end
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_vec
      localparam logic signed [Z_W-1:0] ATAN_K = Z_W'(cpm_pkg::atan_q30(k));
      logic signed [V_W-1:0] dx, dy;
      assign dx = vy_ff[k] >>> k;
      assign dy = vx_ff[k] >>> k;
      always_ff @(posedge clock) begin
         if (en) begin
            if (vy_ff[k] > 0) begin
               vx_ff[k+1] <= vx_ff[k] + dx;
               vy_ff[k+1] <= vy_ff[k] - dy;
               z_ff[k+1]  <= z_ff[k] + ATAN_K;
            end else begin
               vx_ff[k+1] <= vx_ff[k] - dx;
               vy_ff[k+1] <= vy_ff[k] + dy;
               z_ff[k+1]  <= z_ff[k] - ATAN_K;
            end
         end
      end
   end

   // magnitude times 0.666, truncated toward zero, in two partial products
   assign zmag = z_ff[STEPS][Z_W-1] ? Z_W'(-z_ff[STEPS]) : z_ff[STEPS];
   assign psum = ((Z_W+30)'(phi_ff) << LO_W) + (Z_W+30)'(plo_ff);
   assign pq   = psum[Z_W+29:cpm_pkg::FRAC_W];

   always_ff @(posedge clock) begin
      if (en) begin
         plo_ff <= zmag[LO_W-1:0] * cpm_pkg::POW_Q30;
         phi_ff <= zmag[Z_W-1:LO_W] * cpm_pkg::POW_Q30;
         neg_ff <= z_ff[STEPS][Z_W-1];
         phi    <= neg_ff ? -cpm_pkg::PHI_W'(pq) : cpm_pkg::PHI_W'(pq);
      end
   end

endmodule

// ===== rtl/core/cpm_expo.sv =====
// ----------------------------------------------------------------------------
// cpm_expo: radius from the logarithm
// Scale by 0.333, then 2^frac by root products, gain compensation, shift.
// ----------------------------------------------------------------------------
module cpm_expo (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [cpm_pkg::LG_W-1:0]   lg,
   output logic [cpm_pkg::ROT_W-1:0]         r0
);

   localparam int LG_W  = cpm_pkg::LG_W;
   localparam int U_W   = cpm_pkg::U_W;
   localparam int N_W   = cpm_pkg::N_W;
   localparam int FW    = cpm_pkg::FRAC_W;
   localparam int STEPS = cpm_pkg::STEPS;
   localparam int LO_W  = 18;
   localparam int P_W   = LG_W + 29;

   logic [LG_W-1:0]        mag;
   logic [LO_W+28:0]       plo_ff;
   logic [LG_W-LO_W+28:0]  phi_ff;
   logic                   neg_ff;
   logic [P_W-1:0]         psum;
   logic [P_W-FW-1:0]      pq;
   logic signed [U_W:0]    us;
   logic [U_W-1:0]         u_ff;

   logic [30:0]     acc_ff [0:STEPS];
   logic [FW-1:0]   g_ff   [0:STEPS];
   logic [N_W-1:0]  n_ff   [0:STEPS];
   logic [60:0]     bprod;
   logic [30:0]     base_ff;
   logic [N_W-1:0]  nb_ff;

   assign mag  = lg[LG_W-1] ? LG_W'(-lg) : lg;
   assign psum = (P_W'(phi_ff) << LO_W) + P_W'(plo_ff);
   assign pq   = psum[P_W-1:FW];
   assign us   = (neg_ff ? -$signed({1'b0, (U_W)'(pq)}) : $signed({1'b0, (U_W)'(pq)}))
               + (U_W+1)'(longint'(16) << FW);

   always_ff @(posedge clock) begin
      if (en) begin
         plo_ff    <= mag[LO_W-1:0] * cpm_pkg::THIRD_Q30;
         phi_ff    <= mag[LG_W-1:LO_W] * cpm_pkg::THIRD_Q30;
         neg_ff    <= lg[LG_W-1];
         u_ff      <= us[U_W-1:0];
         acc_ff[0] <= 31'(longint'(1) << FW);
         g_ff[0]   <= u_ff[FW-1:0];
         n_ff[0]   <= u_ff[U_W-1:FW];
      end
   end

   for (genvar k = 1; k <= STEPS; k++) begin : g_exp
      localparam logic [30:0] ROOT = cpm_pkg::exp_root(k);
      logic [61:0] prod;
      assign prod = acc_ff[k-1] * ROOT;
      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff[k] <= g_ff[k-1][FW-k] ? prod[60:30] : acc_ff[k-1];
            g_ff[k]   <= g_ff[k-1];
            n_ff[k]   <= n_ff[k-1];
         end
      end
   end

   assign bprod = acc_ff[STEPS] * cpm_pkg::KINV_Q30;

   always_ff @(posedge clock) begin
      if (en) begin
         base_ff <= bprod[60:30];
         nb_ff   <= n_ff[STEPS];
         if (nb_ff <= N_W'(cpm_pkg::R0_POINT)) begin
            r0 <= cpm_pkg::ROT_W'(base_ff) >> (N_W'(cpm_pkg::R0_POINT) - nb_ff);
         end else begin
            r0 <= cpm_pkg::ROT_W'(base_ff) << (nb_ff - N_W'(cpm_pkg::R0_POINT));
         end
      end
   end

endmodule

// ===== rtl/core/cpm_rotate.sv =====
// ----------------------------------------------------------------------------
// cpm_rotate: rotation CORDIC from polar to rectangular
// Quarter pre-turn, one step per stage, then round off the guard bits.
// ----------------------------------------------------------------------------
module cpm_rotate (
   input  logic                              clock,
   input  logic                              en,
   input  logic [cpm_pkg::ROT_W-1:0]         r0,
   input  logic signed [cpm_pkg::PHI_W-1:0]  phi,
   output logic signed [cpm_pkg::RES_W-1:0]  xr,
   output logic signed [cpm_pkg::RES_W-1:0]  yr
);

   localparam int RW    = cpm_pkg::ROT_W;
   localparam int PW    = cpm_pkg::PHI_W;
   localparam int STEPS = cpm_pkg::STEPS;
   localparam logic signed [PW-1:0] HALF_PI = PW'(cpm_pkg::HALF_PI_Q30);
   localparam logic signed [RW-1:0] ROUND   = RW'(8);

   logic signed [RW-1:0] cx_ff [0:STEPS];
   logic signed [RW-1:0] cy_ff [0:STEPS];
   logic signed [PW-1:0] z_ff  [0:STEPS];
   logic signed [RW-1:0] rs;
   logic signed [RW-1:0] tx, ty;

   assign rs = $signed(r0);

   always_ff @(posedge clock) begin
      if (en) begin
         if (phi > HALF_PI) begin
            cx_ff[0] <= '0;
            cy_ff[0] <= rs;
            z_ff[0]  <= phi - HALF_PI;
         end else if (phi < -HALF_PI) begin
            cx_ff[0] <= '0;
            cy_ff[0] <= -rs;
            z_ff[0]  <= phi + HALF_PI;
         end else begin
            cx_ff[0] <= rs;
            cy_ff[0] <= '0;
            z_ff[0]  <= phi;
         end
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_rot
      localparam logic signed [PW-1:0] ATAN_K = PW'(cpm_pkg::atan_q30(k));
      logic signed [RW-1:0] dx, dy;
      assign dx = cy_ff[k] >>> k;
      assign dy = cx_ff[k] >>> k;
      always_ff @(posedge clock) begin
         if (en) begin
            if (z_ff[k] >= 0) begin
               cx_ff[k+1] <= cx_ff[k] - dx;
               cy_ff[k+1] <= cy_ff[k] + dy;
               z_ff[k+1]  <= z_ff[k] - ATAN_K;
            end else begin
               cx_ff[k+1] <= cx_ff[k] + dx;
               cy_ff[k+1] <= cy_ff[k] - dy;
               z_ff[k+1]  <= z_ff[k] + ATAN_K;
            end
         end
      end
   end

   assign tx = cx_ff[STEPS] + ROUND;
   assign ty = cy_ff[STEPS] + ROUND;

   always_ff @(posedge clock) begin
      if (en) begin
         xr <= tx[RW-1:4];
         yr <= ty[RW-1:4];
      end
   end

endmodule

// ===== rtl/core/complex_power_map_pixel.sv =====
// ----------------------------------------------------------------------------
// complex_power_map_pixel: per-pixel z^0.666 warp of a coordinate map
// Streams pixels (chan0, chan1, inversion count) through a fixed pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one pixel per transfer; rsp_* returns one result per pixel,
//   in order. Each pixel maps x = -chan1, y = chan0 to the polar power
//   (r^0.666 angle scaling) and returns (real - shift_a, imag, count).
//   A pixel with a negative count returns -1000 in all three fields.
//   csr_we/csr_wdata set shift_a (unsigned Q15.16, clamped to at least 66); write it
//   only while no pixel is in flight.
// Rate:
//   one pixel per cycle sustained while rsp_tready does not hold the
//   pipeline. The pipeline depth is set by the three 30-step chains:
//   the log2 squaring recurrence, the 2^frac root products and the rotation
//   CORDIC, each one stage per step, in series.
// Reset and stall:
//   reset clears every valid bit and loads shift_a with 1.0. When rsp_tready
//   is low with a result waiting, the whole pipeline holds in place and
//   req_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module complex_power_map_pixel #(
   parameter int COORD_WIDTH = cpm_pkg::COORD_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,

   input  logic req_tvalid,
   output logic req_tready,
   // chan0_in, chan1_in, inversions_in (low bit up), zero pad to bytes
   input  logic [((2*COORD_WIDTH+16+7)/8)*8-1:0] req_tdata,

   output logic rsp_tvalid,
   input  logic rsp_tready,
   // chan0_out, chan1_out, inversions_out (low bit up), zero pad to bytes
   output logic [((2*COORD_WIDTH+16+7)/8)*8-1:0] rsp_tdata,

   input  logic                      csr_we,
   input  logic [cpm_pkg::CFG_W-1:0] csr_wdata
);

   localparam int CW      = COORD_WIDTH;
   localparam int TD_W    = ((2*COORD_WIDTH+16+7)/8)*8;
   localparam int SH      = (CW > 32) ? (CW - 32) : 0;
   localparam int RES_W   = cpm_pkg::RES_W;
   localparam int D_W     = RES_W + 1;
   localparam int SIDE_W  = $bits(cpm_pkg::side_type);
   localparam int PHI_DLY = cpm_pkg::LOG_LAT + cpm_pkg::EXP_LAT - cpm_pkg::ATAN_LAT;
   localparam int SIDE_DLY = cpm_pkg::LOG_LAT + cpm_pkg::EXP_LAT + cpm_pkg::ROT_LAT;
   localparam int TOTAL_LAT = SIDE_DLY + 2;
   localparam logic signed [D_W-1:0] C_MAX = D_W'((longint'(1) << (CW - 1)) - 1);
   localparam logic signed [D_W-1:0] C_MIN = -C_MAX - D_W'(1);

   // configuration register, stored already clamped
   logic [cpm_pkg::CFG_W-1:0] shift_a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_a_ff <= cpm_pkg::SHIFT_A_RST;
      end else if (csr_we) begin
         shift_a_ff <= (csr_wdata < cpm_pkg::SHIFT_A_MIN) ? cpm_pkg::SHIFT_A_MIN : csr_wdata;
      end
   end

   // advance every stage together whenever the output register can move
   logic en;
   logic [TOTAL_LAT-1:0] vld_ff;

   assign en         = !vld_ff[TOTAL_LAT-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[TOTAL_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[TOTAL_LAT-2:0], req_tvalid};
      end
   end

   // input stage: unpack, negate chan1, flag invalid and zero-length pixels
   logic signed [CW-1:0]   c0, c1;
   logic [cpm_pkg::CNT_W-1:0] cnt;
   logic signed [CW:0]     x_in, y_in;
   logic [CW:0]            abs_x, abs_y;
   logic signed [CW:0]     x0_ff, y0_ff;
   cpm_pkg::side_type      side_in, side0_ff, side_d;

   assign c0    = req_tdata[CW-1:0];
   assign c1    = req_tdata[2*CW-1:CW];
   assign cnt   = req_tdata[2*CW+cpm_pkg::CNT_W-1:2*CW];
   assign x_in  = -(CW+1)'(c1);
   assign y_in  = (CW+1)'(c0);
   assign abs_x = x_in[CW] ? (CW+1)'(-x_in) : x_in;
   assign abs_y = y_in[CW] ? (CW+1)'(-y_in) : y_in;

   always_comb begin
      side_in.bad  = cnt[cpm_pkg::CNT_W-1];
      side_in.zero = ((abs_x >> SH) == '0) && ((abs_y >> SH) == '0);
      side_in.cnt  = cnt;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff    <= x_in;
         y0_ff    <= y_in;
         side0_ff <= side_in;
      end
   end

   // radius path: log2 of |z|^2, then exponent and gain compensation
   logic signed [cpm_pkg::LG_W-1:0] lg;
   logic [cpm_pkg::ROT_W-1:0]       r0;

   cpm_log2 #(.COORD_WIDTH(COORD_WIDTH)) u_log2 (
      .clock (clock),
      .en    (en),
      .x     (x0_ff),
      .y     (y0_ff),
      .lg    (lg)
   );

   cpm_expo u_expo (
      .clock (clock),
      .en    (en),
      .lg    (lg),
      .r0    (r0)
   );

   // angle path runs beside the log, then waits for the radius
   logic signed [cpm_pkg::PHI_W-1:0] phi, phi_d;

   cpm_atan #(.COORD_WIDTH(COORD_WIDTH)) u_atan (
      .clock (clock),
      .en    (en),
      .x     (x0_ff),
      .y     (y0_ff),
      .phi   (phi)
   );

   cpm_delay #(.WIDTH(cpm_pkg::PHI_W), .DEPTH(PHI_DLY)) u_phi_dly (
      .clock (clock),
      .en    (en),
      .d     (phi),
      .q     (phi_d)
   );

   logic signed [RES_W-1:0] xr, yr;

   cpm_rotate u_rotate (
      .clock (clock),
      .en    (en),
      .r0    (r0),
      .phi   (phi_d),
      .xr    (xr),
      .yr    (yr)
   );

   cpm_delay #(.WIDTH(SIDE_W), .DEPTH(SIDE_DLY)) u_side_dly (
      .clock (clock),
      .en    (en),
      .d     (side0_ff),
      .q     (side_d)
   );

   // output stage: drop zero-vector results, subtract shift_a, saturate, mark invalid pixels
   logic signed [D_W-1:0]  rx, ry, dx;
   logic signed [CW-1:0]   ox, oy;
   logic [cpm_pkg::CNT_W-1:0] oc;
   logic [TD_W-1:0]        rsp_in, rsp_ff;

   always_comb begin
      rx = side_d.zero ? '0 : D_W'(xr);
      ry = side_d.zero ? '0 : D_W'(yr);
      dx = rx - D_W'(shift_a_ff);
      priority if (dx > C_MAX) begin
         ox = CW'(C_MAX);
      end else if (dx < C_MIN) begin
         ox = CW'(C_MIN);
      end else begin
         ox = CW'(dx);
      end
      priority if (ry > C_MAX) begin
         oy = CW'(C_MAX);
      end else if (ry < C_MIN) begin
         oy = CW'(C_MIN);
      end else begin
         oy = CW'(ry);
      end
      oc = side_d.cnt;
      if (side_d.bad) begin
         ox = CW'(cpm_pkg::INVALID_CODE);
         oy = CW'(cpm_pkg::INVALID_CODE);
         oc = cpm_pkg::CNT_W'(cpm_pkg::INVALID_CODE);
      end
      // zero pad up to whole bytes
      rsp_in = TD_W'({oc, oy, ox});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule

// ===== verif/tb_complex_power_map_pixel.sv =====
// ----------------------------------------------------------------------------
// tb_complex_power_map_pixel: self-checking bench for the z^0.666 pixel warp
// Drives pixels over the req stream, predicts each result with an in-bench
// fixed-point model of the polar power path, and compares the rsp stream.
// ----------------------------------------------------------------------------
module tb_complex_power_map_pixel;

   localparam int CW  = 32;
   localparam int DW  = ((2*CW+16+7)/8)*8;
   localparam int LAT = 102;

   typedef struct packed {
      logic signed [15:0]   cnt;
      logic signed [CW-1:0] c1;
      logic signed [CW-1:0] c0;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [DW-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [DW-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [cpm_pkg::CFG_W-1:0] csr_wdata = '0;

   complex_power_map_pixel #(.COORD_WIDTH(CW)) dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   pixel_type pending_px[$];
   pixel_type warped_px[$];
   longint unsigned shift_reg = 65536;
   int sender_idle_pct = 0, recv_stall_pct = 0;
   int mismatches = 0, results_seen = 0, invalid_seen = 0, zero_seen = 0;

   // Predictor: fixed-point polar power, step for step.
   function automatic longint sra(longint v, int k);
      return v >>> k;
   endfunction

   function automatic longint atan_step(int k);
      return longint'(cpm_pkg::atan_q30(k));
   endfunction

   function automatic longint mul_trunc(longint a, longint unsigned c);
      longint unsigned mag, p;
      mag = a < 0 ? -a : a;
      p = (mag * c) >> 30;
      return a < 0 ? -longint'(p) : longint'(p);
   endfunction

   function automatic longint unsigned pow2_frac(longint unsigned g);
      longint unsigned acc, c;
      acc = 64'd1 << 30;
      c = cpm_pkg::isqrt64(64'd1 << 61);
      for (int k = 1; k <= 30; k++) begin
         if ((g >> (30 - k)) & 1) acc = (acc * c) >> 30;
         c = cpm_pkg::isqrt64(c << 30);
      end
      return acc;
   endfunction

   function automatic longint log2_fixed(longint unsigned s);
      int e;
      longint unsigned m;
      longint f;
      e = 0;
      f = 0;
      while (e < 63 && (s >> (e + 1)) != 0) e++;
      m = e >= 30 ? s >> (e - 30) : s << (30 - e);
      for (int i = 29; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            m >>= 1;
            f |= longint'(1) << i;
         end
      end
      return longint'(e) * (longint'(1) << 30) + f;
   endfunction

   function automatic longint clip_coord(longint v);
      longint hi, lo;
      hi = (longint'(1) << (CW - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   function automatic pixel_type warp_pixel(pixel_type p);
      pixel_type o;
      longint x, y, xr, yr, a, lg, u, r0, vx, vy, z, cx, cy, dx, dy;
      longint unsigned ax, ay, s, base;
      int n;
      y = longint'(p.c0);
      x = -longint'(p.c1);
      xr = 0;
      yr = 0;
      if (p.cnt < 0) begin
         o.c0 = CW'(cpm_pkg::INVALID_CODE);
         o.c1 = CW'(cpm_pkg::INVALID_CODE);
         o.cnt = 16'(cpm_pkg::INVALID_CODE);
         return o;
      end
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      s = ax * ax + ay * ay;
      if (s != 0) begin
         lg = log2_fixed(s) - 32 * (longint'(1) << 30);
         u = mul_trunc(lg, cpm_pkg::THIRD_Q30) + 16 * (longint'(1) << 30);
         n = int'(u >> 30);
         base = (pow2_frac(longint'(u) & ((64'd1 << 30) - 1)) * cpm_pkg::KINV_Q30) >> 30;
         r0 = n <= 26 ? base >> (26 - n) : base << (n - 26);
         vx = x;
         vy = y;
         z = 0;
         // left half-plane: fold by pi first
         if (vx < 0) begin
            z = vy >= 0 ? cpm_pkg::PI_Q30 : -cpm_pkg::PI_Q30;
            vx = -vx;
            vy = -vy;
         end
         for (int k = 0; k < 30; k++) begin
            dx = sra(vy, k);
            dy = sra(vx, k);
            if (vy > 0) begin
               vx += dx; vy -= dy; z += atan_step(k);
            end else begin
               vx -= dx; vy += dy; z -= atan_step(k);
            end
         end
         z = mul_trunc(z, cpm_pkg::POW_Q30);
         cx = r0;
         cy = 0;
         if (z > cpm_pkg::HALF_PI_Q30) begin
            cx = 0; cy = r0; z -= cpm_pkg::HALF_PI_Q30;
         end else if (z < -cpm_pkg::HALF_PI_Q30) begin
            cx = 0; cy = -r0; z += cpm_pkg::HALF_PI_Q30;
         end
         for (int k = 0; k < 30; k++) begin
            dx = sra(cy, k);
            dy = sra(cx, k);
            if (z >= 0) begin
               cx -= dx; cy += dy; z -= atan_step(k);
            end else begin
               cx += dx; cy -= dy; z += atan_step(k);
            end
         end
         xr = sra(cx + 8, 4);
         yr = sra(cy + 8, 4);
      end
      a = shift_reg < cpm_pkg::SHIFT_A_MIN ? cpm_pkg::SHIFT_A_MIN : shift_reg;
      o.c0 = CW'(clip_coord(xr - a));
      o.c1 = CW'(clip_coord(yr));
      o.cnt = p.cnt;
      return o;
   endfunction

   // Driver: advance to the next pixel after each transfer, idle at random, stall rsp_tready at random.
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_tready) begin
            if (pending_px.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               pixel_type p;
               p = pending_px.pop_front();
               warped_px.push_back(warp_pixel(p));
               req_tdata <= DW'(p);
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= $urandom_range(99) >= recv_stall_pct;
      end
   end

   // Monitor: compare every result transfer against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         pixel_type got, want;
         got = pixel_type'(rsp_tdata[2*CW+15:0]);
         results_seen++;
         if (warped_px.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
         end else begin
            want = warped_px.pop_front();
            if (got.cnt == -16'sd1000 && want.cnt == -16'sd1000) invalid_seen++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected c0=%0d c1=%0d cnt=%0d, got c0=%0d c1=%0d cnt=%0d",
                           want.c0, want.c1, want.cnt, got.c0, got.c1, got.cnt);
            end
         end
      end
   end

   function automatic logic [CW-1:0] rand_coord();
      case ($urandom_range(5))
         0: return CW'($urandom_range(255)) - CW'(128);
         1: return {$urandom_range(1) ? 16'hFFFF : 16'h0, 16'($urandom)};
         2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         default: return CW'($urandom);
      endcase
   endfunction

   task automatic queue_pixel(logic [CW-1:0] c0, logic [CW-1:0] c1, logic [15:0] cnt);
      pixel_type p;
      p.c0 = c0;
      p.c1 = c1;
      p.cnt = cnt;
      if (c0 == 0 && c1 == 0 && !cnt[15]) zero_seen++;
      pending_px.push_back(p);
   endtask

   // Hold until every queued pixel has gone out and every result is back.
   task automatic drain();
      while (pending_px.size() != 0 || req_tvalid || warped_px.size() != 0)
         @(posedge clock);
      repeat (LAT + 20) @(posedge clock);
   endtask

   task automatic write_shift(longint unsigned v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= cpm_pkg::CFG_W'(v);
      shift_reg = v & 64'h7FFF_FFFF;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_pixels(int count);
      for (int i = 0; i < count; i++)
         queue_pixel(rand_coord(), rand_coord(),
                     $urandom_range(9) == 0 ? 16'($urandom) | 16'h8000 : 16'($urandom) & 16'h7FFF);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero vector, axes, half-plane folds, extremes, invalid counts.
      queue_pixel(0, 0, 0);
      queue_pixel(32'h0001_0000, 0, 1);
      queue_pixel(0, 32'h0001_0000, 2);
      queue_pixel(0, 32'hFFFF_0000, 3);
      queue_pixel(32'hFFFF_0000, 0, 4);
      queue_pixel(32'h0001_0000, 32'h0001_0000, 5);
      queue_pixel(32'hFFFF_0000, 32'hFFFF_0000, 6);
      queue_pixel(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF);
      queue_pixel(32'h8000_0000, 32'h8000_0000, 7);
      queue_pixel(32'h8000_0000, 32'h7FFF_FFFF, 8);
      queue_pixel(32'h7FFF_FFFF, 32'h8000_0000, 9);
      queue_pixel(1, 0, 10);
      queue_pixel(0, 32'hFFFF_FFFF, 11);
      queue_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 12);
      queue_pixel(32'h1234_5678, 32'h9ABC_DEF0, 16'h8000);
      queue_pixel(0, 0, 16'hFFFF);
      queue_pixel(32'h0000_0001, 32'h0000_0001, 16'hFFFF);
      drain();

      // Random phases with varying shift and idle mix; extremes of shift first.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: write_shift(0);
            1: write_shift(65);
            2: write_shift(66);
            3: write_shift(64'h7FFF_FFFF);
            default: write_shift($urandom);
         endcase
         sender_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? 81 : 0;
         recv_stall_pct  = (ph % 4 == 2 || ph % 4 == 3) ? 81 : 0;
         if (ph % 4 == 3) begin
            sender_idle_pct = 6;
            recv_stall_pct = 6;
         end
         random_pixels(150);
         drain();
      end

      $display("covered %0d results, %0d invalid pixels, %0d zero vectors, 9 shift settings",
               results_seen, invalid_seen, zero_seen);
      if (mismatches == 0 && warped_px.size() == 0) begin
         $display("tb_complex_power_map_pixel: done, clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb_complex_power_map_pixel: done, errors");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("timeout");
      $display("tb_complex_power_map_pixel: done, errors");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/cpm_pkg.sv
rtl/core/cpm_delay.sv
rtl/core/cpm_log2.sv
rtl/core/cpm_atan.sv
rtl/core/cpm_expo.sv
rtl/core/cpm_rotate.sv
rtl/core/complex_power_map_pixel.sv
verif/tb_complex_power_map_pixel.sv
